>>> hdl/prj_pkg.sv
`default_nettype none

package prj_pkg;

    // image geometry
    localparam int IMAGE_SIZE = 1024;
    localparam int CENTER     = IMAGE_SIZE / 2;
    localparam int QW         = $clog2(IMAGE_SIZE);   // quotient bits, one cell each

    // field widths
    localparam int COORD_W    = 32;
    localparam int FOCAL_W    = 16;
    localparam int THRESH_W   = 32;
    localparam int PIX_W      = 10;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int PROD_W     = 48;                   // |x*f| < 2^47
    localparam int NUM_W      = 49;                   // c*depth +/- x*f, signed
    localparam int MAG_W      = NUM_W - 1;
    localparam int NSUM_W     = MAG_W + 2;            // 2*|num| + depth
    localparam int DEPTH_W    = 32;
    localparam int DIV_W      = DEPTH_W + 1;          // 2*depth
    localparam int REM_W      = QW + DIV_W;

    localparam logic [QW:0] SIZE_Q = (QW + 1)'(IMAGE_SIZE);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL  = 1'd0,
        REG_THRESH = 1'd1
    } t_reg_idx;

    // word moved along the division chain
    typedef struct packed {
        logic [REM_W-1:0] rem_col;
        logic [REM_W-1:0] rem_row;
        logic [DIV_W-1:0] divisor;
        logic [QW-1:0]    q_col;
        logic [QW-1:0]    q_row;
        logic             neg_col;
        logic             neg_row;
        logic             live;
        logic             mark;
    } t_div_word;

endpackage

`default_nettype wire

>>> hdl/prj_point_if.sv
`default_nettype none

interface prj_point_if;
    import prj_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/prj_pixel_if.sv
`default_nettype none

interface prj_pixel_if;
    import prj_pkg::*;

    logic               valid;
    logic               ready;
    logic               in_view;
    logic               marked;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;

    modport source (output valid, output in_view, output marked, output pixel_row,
                    output pixel_col, input ready);
    modport sink   (input valid, input in_view, input marked, input pixel_row,
                    input pixel_col, output ready);
endinterface

`default_nettype wire

>>> hdl/prj_front.sv
`default_nettype none

module prj_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [prj_pkg::FOCAL_W-1:0]        i_focal,
    input  wire logic signed [prj_pkg::THRESH_W-1:0] i_thresh,
    prj_point_if.sink                               i_point,
    output logic                                    o_valid,
    output prj_pkg::t_div_word                      o_word,
    input  wire logic                               i_ready
);
    import prj_pkg::*;

    // stage valids and ready chain
    logic r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5 = !r5_valid || i_ready;
    assign w_rdy4 = !r4_valid || w_rdy5;
    assign w_rdy3 = !r3_valid || w_rdy4;
    assign w_rdy2 = !r2_valid || w_rdy3;
    assign w_rdy1 = !r1_valid || w_rdy2;
    assign i_point.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (w_rdy1) r1_valid <= i_point.valid;
            if (w_rdy2) r2_valid <= r1_valid;
            if (w_rdy3) r3_valid <= r2_valid;
            if (w_rdy4) r4_valid <= r3_valid;
            if (w_rdy5) r5_valid <= r4_valid;
        end
    end

    // stage 1: products with focal length, depth, flags
    logic signed [FOCAL_W:0]      w_focal_s;
    logic signed [PROD_W:0]       w_xf_full;
    logic signed [PROD_W:0]       w_yf_full;
    logic signed [PROD_W-1:0]     r1_xf;
    logic signed [PROD_W-1:0]     r1_yf;
    logic [DEPTH_W-1:0]           r1_depth;
    logic                         r1_front;
    logic                         r1_mark;

    assign w_focal_s = {1'b0, i_focal};
    assign w_xf_full = i_point.point_x * w_focal_s;
    assign w_yf_full = i_point.point_y * w_focal_s;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_point.valid) begin
            r1_xf    <= w_xf_full[PROD_W-1:0];
            r1_yf    <= w_yf_full[PROD_W-1:0];
            r1_depth <= DEPTH_W'(-i_point.point_z);
            r1_front <= i_point.point_z[COORD_W-1];
            r1_mark  <= i_point.point_z < i_thresh;
        end
    end

    // stage 2: numerators c*depth + x*f and c*depth - y*f
    logic [NUM_W-1:0]             w_cd;
    logic signed [NUM_W-1:0]      r2_ncol;
    logic signed [NUM_W-1:0]      r2_nrow;
    logic [DEPTH_W-1:0]           r2_depth;
    logic                         r2_front;
    logic                         r2_mark;

    assign w_cd = NUM_W'(r1_depth) * NUM_W'(CENTER);

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r1_valid) begin
            r2_ncol  <= $signed(w_cd) + NUM_W'(r1_xf);
            r2_nrow  <= $signed(w_cd) - NUM_W'(r1_yf);
            r2_depth <= r1_depth;
            r2_front <= r1_front;
            r2_mark  <= r1_mark;
        end
    end

    // stage 3: magnitudes and signs
    logic [NUM_W-1:0]             w_acol;
    logic [NUM_W-1:0]             w_arow;
    logic [MAG_W-1:0]             r3_mcol;
    logic [MAG_W-1:0]             r3_mrow;
    logic                         r3_neg_col;
    logic                         r3_neg_row;
    logic [DEPTH_W-1:0]           r3_depth;
    logic                         r3_front;
    logic                         r3_mark;

    assign w_acol = r2_ncol[NUM_W-1] ? -r2_ncol : r2_ncol;
    assign w_arow = r2_nrow[NUM_W-1] ? -r2_nrow : r2_nrow;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r2_valid) begin
            r3_mcol    <= w_acol[MAG_W-1:0];
            r3_mrow    <= w_arow[MAG_W-1:0];
            r3_neg_col <= r2_ncol[NUM_W-1];
            r3_neg_row <= r2_nrow[NUM_W-1];
            r3_depth   <= r2_depth;
            r3_front   <= r2_front;
            r3_mark    <= r2_mark;
        end
    end

    // stage 4: rounded dividend 2*|num| + depth, divisor 2*depth
    logic [NSUM_W-1:0]            r4_ncol;
    logic [NSUM_W-1:0]            r4_nrow;
    logic [DIV_W-1:0]             r4_div;
    logic                         r4_neg_col;
    logic                         r4_neg_row;
    logic                         r4_front;
    logic                         r4_mark;

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r3_valid) begin
            r4_ncol    <= NSUM_W'({r3_mcol, 1'b0}) + NSUM_W'(r3_depth);
            r4_nrow    <= NSUM_W'({r3_mrow, 1'b0}) + NSUM_W'(r3_depth);
            r4_div     <= {r3_depth, 1'b0};
            r4_neg_col <= r3_neg_col;
            r4_neg_row <= r3_neg_row;
            r4_front   <= r3_front;
            r4_mark    <= r3_mark;
        end
    end

    // stage 5: range check so the quotient fits in QW bits, load the chain word
    logic [NSUM_W-1:0]            w_lim;
    logic                         w_ovf_col;
    logic                         w_ovf_row;
    t_div_word                    n_word;
    t_div_word                    r5_word;

    assign w_lim     = NSUM_W'({r4_div, {QW{1'b0}}});
    assign w_ovf_col = r4_ncol >= w_lim;
    assign w_ovf_row = r4_nrow >= w_lim;

    always_comb begin
        n_word.rem_col = r4_ncol[REM_W-1:0];
        n_word.rem_row = r4_nrow[REM_W-1:0];
        n_word.divisor = r4_div;
        n_word.q_col   = '0;
        n_word.q_row   = '0;
        n_word.neg_col = r4_neg_col;
        n_word.neg_row = r4_neg_row;
        n_word.live    = r4_front && !w_ovf_col && !w_ovf_row;
        n_word.mark    = r4_mark;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r4_valid) begin
            r5_word <= n_word;
        end
    end

    assign o_valid = r5_valid;
    assign o_word  = r5_word;

endmodule

`default_nettype wire

>>> hdl/prj_cell.sv
`default_nettype none

module prj_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire prj_pkg::t_div_word i_word,
    output logic                    o_valid,
    output prj_pkg::t_div_word      o_word,
    input  wire logic               i_ready
);
    import prj_pkg::*;

    logic       r_valid;
    t_div_word  r_word;
    t_div_word  n_word;

    logic [REM_W-1:0] w_trial;
    logic             w_ge_col;
    logic             w_ge_row;
    logic [REM_W-1:0] w_rcol;
    logic [REM_W-1:0] w_rrow;

    // one restoring step per axis: compare against divisor << (QW-1), then shift
    assign w_trial  = REM_W'({i_word.divisor, {(QW - 1){1'b0}}});
    assign w_ge_col = i_word.rem_col >= w_trial;
    assign w_ge_row = i_word.rem_row >= w_trial;
    assign w_rcol   = w_ge_col ? i_word.rem_col - w_trial : i_word.rem_col;
    assign w_rrow   = w_ge_row ? i_word.rem_row - w_trial : i_word.rem_row;

    always_comb begin
        n_word         = i_word;
        n_word.rem_col = {w_rcol[REM_W-2:0], 1'b0};
        n_word.rem_row = {w_rrow[REM_W-2:0], 1'b0};
        n_word.q_col   = {i_word.q_col[QW-2:0], w_ge_col};
        n_word.q_row   = {i_word.q_row[QW-2:0], w_ge_row};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

>>> hdl/lidar_point_perspective_projector.sv
`default_nettype none

// Pinhole projection of lidar points onto a square image of IMAGE_SIZE pixels.
// Each input word carries one point (x, y, z in signed Q16.16 metres, camera at
// the origin looking down -z); each output word gives in_view, marked and the
// pixel row and column, rounded half away from zero from the exact quotients
// (c + x*f/depth) and (c - y*f/depth). Points behind the camera or projecting
// off the image come out with every field zero. One point is taken per cycle
// unless the pipeline is full and its output stalled. Five front stages form
// the products and rounded dividends, then a chain of QW division cells
// resolves one quotient bit per cell for both axes, then the output register.
// Every stage has its own valid bit, so empty slots are squeezed out and new
// points keep entering while a result waits downstream until no slot is empty.
// Write focal_length (index 0) and height_threshold (index 1) only while the
// pipeline is empty.
module lidar_point_perspective_projector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [prj_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [prj_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    prj_point_if.sink                               i_point,
    prj_pixel_if.source                             o_result
);
    import prj_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [FOCAL_W-1:0]          r_focal;
    logic signed [THRESH_W-1:0]  r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= FOCAL_W'(80);
            r_thresh <= THRESH_W'(-1777439);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FOCAL:  r_focal  <= i_cfg_data[FOCAL_W-1:0];
                REG_THRESH: r_thresh <= $signed(i_cfg_data[THRESH_W-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Front stages: products, numerators, rounding, range check
    // ---------------------------------------------------------------
    logic       w_valid [0:QW];
    logic       w_ready [0:QW];
    t_div_word  w_word  [0:QW];

    prj_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_focal  (r_focal),
        .i_thresh (r_thresh),
        .i_point  (i_point),
        .o_valid  (w_valid[0]),
        .o_word   (w_word[0]),
        .i_ready  (w_ready[0])
    );

    // ---------------------------------------------------------------
    // Division chain: each cell settles one quotient bit, MSB first
    // ---------------------------------------------------------------
    for (genvar g = 0; g < QW; g++) begin : g_cell
        prj_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_word  (w_word[g]),
            .o_valid (w_valid[g + 1]),
            .o_word  (w_word[g + 1]),
            .i_ready (w_ready[g + 1])
        );
    end

    // ---------------------------------------------------------------
    // Result stage: apply signs and image bounds, hold the output word
    // ---------------------------------------------------------------
    t_div_word          w_last;
    logic               w_col_ok;
    logic               w_row_ok;
    logic               w_view;

    logic               r_out_valid;
    logic               r_out_view;
    logic               r_out_mark;
    logic [PIX_W-1:0]   r_out_row;
    logic [PIX_W-1:0]   r_out_col;

    assign w_last = w_word[QW];

    // a negative numerator is only in view when it rounds to zero
    assign w_col_ok = (!w_last.neg_col || (w_last.q_col == '0))
                      && ((QW + 1)'(w_last.q_col) < SIZE_Q);
    assign w_row_ok = (!w_last.neg_row || (w_last.q_row == '0))
                      && ((QW + 1)'(w_last.q_row) < SIZE_Q);
    assign w_view   = w_last.live && w_col_ok && w_row_ok;

    assign w_ready[QW] = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[QW]) begin
            r_out_valid <= w_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[QW] && w_valid[QW]) begin
            r_out_view <= w_view;
            r_out_mark <= w_view && w_last.mark;
            r_out_row  <= w_view ? PIX_W'(w_last.q_row) : '0;
            r_out_col  <= w_view ? PIX_W'(w_last.q_col) : '0;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.in_view   = r_out_view;
    assign o_result.marked    = r_out_mark;
    assign o_result.pixel_row = r_out_row;
    assign o_result.pixel_col = r_out_col;

`ifndef NO_ASSERTIONS
    a_mark_needs_view: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.marked |-> o_result.in_view)
        else $error("marked word without in_view");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.in_view |->
            (o_result.pixel_row == '0) && (o_result.pixel_col == '0))
        else $error("hidden point carries a pixel position");

    a_focal_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_idx == REG_FOCAL) |=> r_focal == $past(i_cfg_data[FOCAL_W-1:0]))
        else $error("focal length write lost");

    a_chain_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[QW] && !w_ready[QW] |=> w_valid[QW] && $stable(w_last))
        else $error("division chain dropped a stalled word");
`endif

endmodule

`default_nettype wire
